// ===== sv/mavg_pkg.sv =====
// shared widths, field offsets and reset values for the four-channel moving average
`default_nettype none

package mavg_pkg;

    // channel widths as they travel on the stream
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;
    localparam int HUM_W  = 14;
    localparam int ALT_W  = 18;
    localparam int MAX_CH_W = 18;
    localparam int NUM_CH = 4;

    // field offsets inside one stored reading
    localparam int TEMP_LSB = 0;
    localparam int PRES_LSB = TEMP_LSB + TEMP_W;
    localparam int HUM_LSB  = PRES_LSB + PRES_W;
    localparam int ALT_LSB  = HUM_LSB + HUM_W;
    localparam int SAMPLE_W = ALT_LSB + ALT_W;

    // output framing
    localparam int SAMP_CNT_W = 4;
    localparam int SAMP_LSB   = SAMPLE_W;
    localparam int OUT_DATA_W = ((SAMPLE_W + SAMP_CNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - SAMPLE_W - SAMP_CNT_W;

    // channel indexes
    localparam int CH_TEMP = 0;
    localparam int CH_PRES = 1;
    localparam int CH_HUM  = 2;
    localparam int CH_ALT  = 3;

    // bad-read supervision
    localparam int THR_W = 3;
    localparam int BAD_W = 3;
    localparam logic [THR_W-1:0] THR_RESET = 3'd5;

    // default window and derived divider widths
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int DIVIDEND_W_DEF   = MAX_CH_W + $clog2(WINDOW_DEPTH_DEF);
    localparam int DIVISOR_W_DEF    = $clog2(WINDOW_DEPTH_DEF + 1);

endpackage

`default_nettype wire

// ===== sv/four_channel_moving_average.sv =====
// top level: four-channel ring-window moving average with bad-read supervision
`default_nettype none

// Four-channel moving average. Each request on the slave stream carries one reading
// (temperature, pressure, humidity, altitude) and a validity flag in tuser. A valid
// reading is written into one shared window memory of WINDOW_DEPTH entries (all four
// channels side by side in one 64-bit word), then the stored entries are read back
// one per cycle and summed per channel, and four radix-2 dividers divide the sums by
// the fill count, truncating toward zero. The time a valid reading takes is set by
// the single read port of the window memory and by the dividers producing one
// quotient bit a cycle over a dividend of SUM_W bits (21 at the default depth of 8).
// An invalid reading skips the window memory and the dividers and goes straight
// to the done state. One reading is in flight at a time, but the next one is
// taken while a finished result still waits in the output register. The window
// memory needs no clearing: only entries already written are ever read.
module four_channel_moving_average #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // temperature_sample, pressure_sample, humidity_sample, altitude_sample
    input  wire logic [mavg_pkg::SAMPLE_W-1:0]     i_s_tdata,
    // reading_valid
    input  wire logic                              i_s_tuser,
    // master stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // temperature_average, pressure_average, humidity_average, altitude_average,
    // samples_in_window, zero padding
    output logic [mavg_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    // averages_valid, reinit_request
    output logic [1:0]                             o_m_tuser,
    // reinit threshold register
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [mavg_pkg::THR_W-1:0]        i_cfg_wr_data
);
    import mavg_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = MAX_CH_W + IDX_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;

    // window memory, one entry per valid reading
    logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]     r_rd_data;
    logic                    r_rd_vld;
    logic [CNT_W-1:0]        r_rd_cnt;
    logic                    rd_en;

    // ring state
    logic [IDX_W-1:0]        r_wr_pos;
    logic [CNT_W-1:0]        r_fill;
    logic [BAD_W-1:0]        r_bad;
    logic [BAD_W-1:0]        bad_inc;
    logic [THR_W-1:0]        r_thr;

    // per-item result flags
    logic                    r_avg_valid;
    logic                    r_reinit;

    // accumulators and dividers
    logic signed [SUM_W-1:0] r_sum  [NUM_CH];
    logic signed [SUM_W-1:0] ext    [NUM_CH];
    logic signed [SUM_W-1:0] quo    [NUM_CH];
    logic [NUM_CH-1:0]       div_done;
    logic                    r_div_start;

    // output register
    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_data;
    logic [1:0]              r_m_user;

    logic                    in_acc;
    logic                    out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign bad_inc    = r_bad + 1'b1;
    // walk entries 0 .. fill-1, written entries only
    assign rd_en      = (r_state == ST_SUM) && (r_rd_cnt < r_fill);

    // threshold register; write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // window memory: write at accept of a valid reading, registered read during the sum pass
    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tuser) begin
            mem[r_wr_pos] <= i_s_tdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_cnt[IDX_W-1:0]];
        end
    end

    // sign- or zero-extend each channel of the word just read
    always_comb begin
        ext[CH_TEMP] = {{(SUM_W-TEMP_W){r_rd_data[TEMP_LSB+TEMP_W-1]}},
                        r_rd_data[TEMP_LSB +: TEMP_W]};
        ext[CH_PRES] = {{(SUM_W-PRES_W){1'b0}}, r_rd_data[PRES_LSB +: PRES_W]};
        ext[CH_HUM]  = {{(SUM_W-HUM_W){1'b0}}, r_rd_data[HUM_LSB +: HUM_W]};
        ext[CH_ALT]  = {{(SUM_W-ALT_W){r_rd_data[ALT_LSB+ALT_W-1]}},
                        r_rd_data[ALT_LSB +: ALT_W]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // an invalid reading skips the window work entirely
                    n_state = i_s_tuser ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM: begin
                // last entry is being accumulated on this edge
                if (r_rd_vld && (r_rd_cnt == r_fill)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (&div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer, ring pointers and bad-read counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_bad       <= '0;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == ST_SUM) && (n_state == ST_DIV);
            r_rd_vld    <= rd_en;
            if (in_acc) begin
                if (i_s_tuser) begin
                    r_bad    <= '0;
                    r_wr_pos <= (r_wr_pos == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                        : r_wr_pos + 1'b1;
                    if (r_fill < CNT_W'(WINDOW_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end else begin
                    // counter clears when it reaches the threshold
                    r_bad <= (bad_inc >= r_thr) ? '0 : bad_inc;
                end
            end
        end
    end

    // per-item flags, read counter and channel sums
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_avg_valid <= i_s_tuser;
            r_reinit    <= !i_s_tuser && (bad_inc >= r_thr);
            r_rd_cnt    <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (r_rd_vld) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= r_sum[c] + ext[c];
                end
            end
        end
    end

    // one divider per channel, all started together
    for (genvar c = 0; c < NUM_CH; c++) begin : g_div
        mavg_div #(
            .DIVIDEND_W (SUM_W),
            .DIVISOR_W  (CNT_W)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_div_start),
            .i_dividend (r_sum[c]),
            .i_divisor  (r_fill),
            .o_done     (div_done[c]),
            .o_quotient (quo[c])
        );
    end

    // output register, loaded when the previous result is gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            if (r_avg_valid) begin
                r_m_data <= {{OUT_PAD_W{1'b0}}, SAMP_CNT_W'(r_fill),
                             quo[CH_ALT][ALT_W-1:0], quo[CH_HUM][HUM_W-1:0],
                             quo[CH_PRES][PRES_W-1:0], quo[CH_TEMP][TEMP_W-1:0]};
            end else begin
                // no averages on a bad read, count still reported
                r_m_data <= {{OUT_PAD_W{1'b0}}, SAMP_CNT_W'(r_fill), {SAMPLE_W{1'b0}}};
            end
            r_m_user <= {r_reinit, r_avg_valid};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == ST_DONE)
        else $error("result presented without finishing an item");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("reinit request on a valid reading");

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == ST_DIV) && r_avg_valid)
        else $error("divider started outside the divide step");
`endif

endmodule

`default_nettype wire

// ===== sv/mavg_div.sv =====
// signed by unsigned radix-2 divider, one quotient bit a cycle, truncates toward zero
`default_nettype none

module mavg_div #(
    parameter int DIVIDEND_W = mavg_pkg::DIVIDEND_W_DEF,
    parameter int DIVISOR_W  = mavg_pkg::DIVISOR_W_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed [DIVIDEND_W-1:0]      o_quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic                  r_neg;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  take;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        take     = rem_sh >= {1'b0, r_dvs};
        rem_diff = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVIDEND_W - 1);
                r_neg  <= i_dividend[DIVIDEND_W-1];
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                // magnitude; quotient bits shift in from the bottom
                r_quo  <= i_dividend[DIVIDEND_W-1] ? unsigned'(-i_dividend)
                                                   : unsigned'(i_dividend);
            end else if (r_busy) begin
                r_rem <= take ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], take};
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule

`default_nettype wire
